// ----- rtl/hvbp_pkg.sv -----
// shared types, constants and helper function of the hybrid vote branch predictor
package hvbp_pkg;

  localparam int IndexBits    = 12;
  localparam int CounterWidth = 8;
  localparam int AddressWidth = 48;
  localparam int CountWidth   = 32;
  localparam int CfgWidth     = 3;
  localparam int TableDepth   = 1 << IndexBits;

  localparam logic [CfgWidth-1:0] CounterBitsReset = CfgWidth'(2);

  // taken for vote codes 0101, 0110, 0111 and 1xxx except 1000
  localparam logic [15:0] VoteTakenMask = 16'hFEE0;

  localparam logic [CounterWidth-1:0] CounterReset = '1;
  localparam logic [CounterWidth-1:0] CounterCap   = {1'b0, {(CounterWidth-1){1'b1}}};

  typedef struct packed {
    logic [AddressWidth-1:0] branch_address;
    logic                    outcome_taken;
  } in_word_t;

  typedef struct packed {
    logic                  prediction;
    logic                  correct;
    logic [CountWidth-1:0] hit_count;
    logic [CountWidth-1:0] branch_count;
  } out_word_t;

  typedef struct packed {
    logic                    prediction;
    logic                    correct;
    logic [CounterWidth-1:0] hist_next;
    logic [CounterWidth-1:0] gsh_next;
  } vote_res_t;

  typedef struct packed {
    logic [1:0] fill;
  } fifo_status_t;

  // upper saturation bound for a given counter size
  function automatic logic [CounterWidth-1:0] ctr_upper(logic [CfgWidth-1:0] cb);
    int n;
    n = (cb == '0) ? 1 : int'(cb);
    if (n - 1 >= CounterWidth - 1) begin
      return CounterCap;
    end
    return CounterWidth'(1) << (n - 1);
  endfunction

endpackage

// ----- rtl/hvbp_ram.sv -----
// generic single write, single registered read port ram (read-first)
module hvbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ----- rtl/hvbp_vote.sv -----
// vote table lookup and saturating counter update for one branch
module hvbp_vote (
  input  logic [hvbp_pkg::CounterWidth-1:0] hist_ctr_i,
  input  logic [hvbp_pkg::CounterWidth-1:0] gsh_ctr_i,
  input  logic                              bias_i,
  input  logic                              taken_i,
  input  logic [hvbp_pkg::CfgWidth-1:0]     counter_bits_i,
  output hvbp_pkg::vote_res_t               res_o
);
  import hvbp_pkg::*;

  logic [CounterWidth-1:0] hi, lo;
  logic                    v_hist, v_gsh, v_comb;
  logic [3:0]              vote;
  logic                    pred;

  function automatic logic [CounterWidth-1:0] step_ctr(logic [CounterWidth-1:0] c,
                                                        logic up,
                                                        logic [CounterWidth-1:0] l,
                                                        logic [CounterWidth-1:0] h);
    logic [CounterWidth-1:0] r;
    r = c;
    if (up) begin
      if ($signed(c) < $signed(h)) r = c + CounterWidth'(1);
    end else begin
      if ($signed(c) > $signed(l)) r = c - CounterWidth'(1);
    end
    return r;
  endfunction

  always_comb begin
    hi     = ctr_upper(counter_bits_i);
    lo     = CounterWidth'(1) - hi;
    v_hist = $signed(hist_ctr_i) > $signed(CounterWidth'(0));
    v_gsh  = $signed(gsh_ctr_i) > $signed(CounterWidth'(0));
    v_comb = v_gsh | bias_i;
    vote   = {v_comb, v_hist, v_gsh, bias_i};
    pred   = VoteTakenMask[vote];
    res_o.prediction = pred;
    res_o.correct    = (pred == taken_i);
    res_o.hist_next  = step_ctr(hist_ctr_i, taken_i, lo, hi);
    res_o.gsh_next   = step_ctr(gsh_ctr_i, taken_i, lo, hi);
  end

endmodule

// ----- rtl/hvbp_out_fifo.sv -----
// two-word result buffer between the update stage and the output channel
module hvbp_out_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  hvbp_pkg::out_word_t     push_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output hvbp_pkg::out_word_t     out_word_o,
  output hvbp_pkg::fifo_status_t  status_o
);
  import hvbp_pkg::*;

  out_word_t  slot_q [2];
  logic       rd_ptr_q, rd_ptr_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       pop;

  assign out_valid_o   = (fill_q != 2'd0);
  assign out_word_o    = slot_q[rd_ptr_q];
  assign pop           = out_valid_o && !out_stall_i;
  assign status_o.fill = fill_q;

  always_comb begin
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// ----- rtl/hybrid_vote_branch_predictor.sv -----
// hybrid vote branch predictor: gshare, global-history and last-outcome tables
// a word accepted at the input is registered into stage 1, then written to the result buffer
// throughput: one word per cycle while the output does not stall and no clearing pass runs,
// set by the table read and write-back with forwarding from the write of the previous word
// reset: history and counts clear and the counter size returns to two at once;
// a clearing pass then sets the counter tables to minus one and the bias bits to zero
module hybrid_vote_branch_predictor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hvbp_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hvbp_pkg::out_word_t             out_word_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hvbp_pkg::CfgWidth-1:0]   cfg_data_i
);
  import hvbp_pkg::*;

  // control state
  logic                    clear_q, clear_d;
  logic [IndexBits-1:0]    clr_idx_q, clr_idx_d;
  logic [CfgWidth-1:0]     cbits_q;
  logic [IndexBits-1:0]    hist_q, hist_d;
  logic                    s1_valid_q;
  logic [CountWidth-1:0]   hits_q, hits_d;
  logic [CountWidth-1:0]   branches_q, branches_d;
  logic                    lw_valid_q;

  // stage 1 payload
  logic [IndexBits-1:0]    s1_hidx_q, s1_gidx_q, s1_bidx_q;
  logic                    s1_taken_q;

  // last write, for forwarding
  logic [IndexBits-1:0]    lw_hidx_q, lw_gidx_q, lw_bidx_q;
  logic [CounterWidth-1:0] lw_hdata_q, lw_gdata_q;
  logic                    lw_bdata_q;

  logic                    in_accept, out_pop;
  logic [IndexBits-1:0]    rd_hidx, rd_gidx, rd_bidx;
  logic [CounterWidth-1:0] ram_hist, ram_gsh;
  logic                    ram_bias;
  logic [CounterWidth-1:0] hist_ctr, gsh_ctr;
  logic                    bias_bit;
  vote_res_t               res;
  out_word_t               res_word;
  fifo_status_t            fifo_st;

  logic                    wr_en;
  logic [IndexBits-1:0]    wr_hidx, wr_gidx, wr_bidx;
  logic [CounterWidth-1:0] wr_hdata, wr_gdata;
  logic                    wr_bdata;

  assign cfg_ready_o = 1'b1;
  assign out_pop     = out_valid_o && !out_stall_i;
  // stall during the clearing pass or while stage 1 and the buffer, less this cycle's pop, hold more than one word
  assign in_stall_o  = clear_q ||
                       ((3'(fifo_st.fill) + 3'(s1_valid_q) - 3'(out_pop)) > 3'd1);
  assign in_accept   = in_valid_i && !in_stall_o;

  assign rd_hidx = hist_q;
  assign rd_bidx = in_word_i.branch_address[IndexBits-1:0];
  assign rd_gidx = hist_q ^ rd_bidx;

  always_comb begin
    clear_d   = clear_q;
    clr_idx_d = clr_idx_q;
    if (clear_q) begin
      clr_idx_d = clr_idx_q + IndexBits'(1);
      if (clr_idx_q == '1) clear_d = 1'b0;
    end
    hist_d = in_accept ? {hist_q[IndexBits-2:0], in_word_i.outcome_taken} : hist_q;
  end

  // write port: clearing pass or stage 1 write-back
  always_comb begin
    if (clear_q) begin
      wr_en    = 1'b1;
      wr_hidx  = clr_idx_q;
      wr_gidx  = clr_idx_q;
      wr_bidx  = clr_idx_q;
      wr_hdata = CounterReset;
      wr_gdata = CounterReset;
      wr_bdata = 1'b0;
    end else begin
      wr_en    = s1_valid_q;
      wr_hidx  = s1_hidx_q;
      wr_gidx  = s1_gidx_q;
      wr_bidx  = s1_bidx_q;
      wr_hdata = res.hist_next;
      wr_gdata = res.gsh_next;
      wr_bdata = s1_taken_q;
    end
  end

  hvbp_ram #(.Width(CounterWidth), .Depth(TableDepth)) u_hist_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_hidx),
    .wr_data_i (wr_hdata),
    .rd_addr_i (rd_hidx),
    .rd_data_o (ram_hist)
  );

  hvbp_ram #(.Width(CounterWidth), .Depth(TableDepth)) u_gsh_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_gidx),
    .wr_data_i (wr_gdata),
    .rd_addr_i (rd_gidx),
    .rd_data_o (ram_gsh)
  );

  hvbp_ram #(.Width(1), .Depth(TableDepth)) u_bias_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_bidx),
    .wr_data_i (wr_bdata),
    .rd_addr_i (rd_bidx),
    .rd_data_o (ram_bias)
  );

  // the ram returns old data when written at the same edge it was read
  always_comb begin
    hist_ctr = (lw_valid_q && lw_hidx_q == s1_hidx_q) ? lw_hdata_q : ram_hist;
    gsh_ctr  = (lw_valid_q && lw_gidx_q == s1_gidx_q) ? lw_gdata_q : ram_gsh;
    bias_bit = (lw_valid_q && lw_bidx_q == s1_bidx_q) ? lw_bdata_q : ram_bias;
  end

  hvbp_vote u_vote (
    .hist_ctr_i     (hist_ctr),
    .gsh_ctr_i      (gsh_ctr),
    .bias_i         (bias_bit),
    .taken_i        (s1_taken_q),
    .counter_bits_i (cbits_q),
    .res_o          (res)
  );

  always_comb begin
    hits_d     = hits_q;
    branches_d = branches_q;
    if (s1_valid_q) begin
      if (res.correct && hits_q != '1) hits_d = hits_q + CountWidth'(1);
      if (branches_q != '1) branches_d = branches_q + CountWidth'(1);
    end
    res_word.prediction   = res.prediction;
    res_word.correct      = res.correct;
    res_word.hit_count    = hits_d;
    res_word.branch_count = branches_d;
  end

  hvbp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_word_i (res_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .status_o    (fifo_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_idx_q  <= '0;
      cbits_q    <= CounterBitsReset;
      hist_q     <= '0;
      s1_valid_q <= 1'b0;
      hits_q     <= '0;
      branches_q <= '0;
      lw_valid_q <= 1'b0;
    end else begin
      clear_q    <= clear_d;
      clr_idx_q  <= clr_idx_d;
      if (cfg_valid_i && cfg_ready_o) cbits_q <= cfg_data_i;
      hist_q     <= hist_d;
      s1_valid_q <= in_accept;
      hits_q     <= hits_d;
      branches_q <= branches_d;
      lw_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_hidx_q  <= rd_hidx;
      s1_gidx_q  <= rd_gidx;
      s1_bidx_q  <= rd_bidx;
      s1_taken_q <= in_word_i.outcome_taken;
    end
    lw_hidx_q  <= s1_hidx_q;
    lw_gidx_q  <= s1_gidx_q;
    lw_bidx_q  <= s1_bidx_q;
    lw_hdata_q <= res.hist_next;
    lw_gdata_q <= res.gsh_next;
    lw_bdata_q <= s1_taken_q;
  end

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !in_accept) else $error("word accepted during clearing pass");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (fifo_st.fill < 2'd2 || out_pop))
    else $error("result buffer overflow");

  a_branch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && branches_q != '1) |=> branches_q == $past(branches_q) + CountWidth'(1))
    else $error("branch count did not advance");

  a_stage_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q) else $error("accepted word lost before update");

endmodule

// ----- bench/hybrid_vote_branch_predictor_test.sv -----
// self-checking bench for the hybrid vote branch predictor with its own table predictor
`timescale 1ns / 1ps

module hybrid_vote_branch_predictor_test;
  import hvbp_pkg::*;

  typedef logic signed [CounterWidth-1:0] ctr_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgWidth-1:0] cfg_data_i  = '0;

  hybrid_vote_branch_predictor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state
  logic [IndexBits-1:0]  branch_history;
  ctr_t                  history_ctr [TableDepth];
  ctr_t                  gshare_ctr  [TableDepth];
  logic                  last_taken  [TableDepth];
  logic [CountWidth-1:0] hit_total;
  logic [CountWidth-1:0] branch_total;
  logic [CfgWidth-1:0]   counter_size;

  out_word_t expected_words [$];

  // loop-like branches for the random part
  logic [AddressWidth-1:0] loop_addr   [8];
  int                      loop_period [8];
  int                      loop_trip   [8];

  bit        tx_gaps_on   = 1'b1;
  bit        rx_stalls_on = 1'b1;
  int        rx_hold_len  = 0;
  int        mismatches   = 0;
  int        words_sent   = 0;
  int        results_seen = 0;
  logic [7:0] sizes_used  = '0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(400_000 * 12);
    $display("timeout: %0d words sent, %0d results seen", words_sent, results_seen);
    $display("hybrid_vote_branch_predictor_test: FAIL");
    $finish;
  end

  function automatic ctr_t step_counter(ctr_t c, logic up, int lo_b, int hi_b);
    int v;
    v = c;
    if (up) begin
      if (v < hi_b) v++;
    end else begin
      if (v > lo_b) v--;
    end
    return ctr_t'(v);
  endfunction

  function automatic out_word_t predict_branch(in_word_t w);
    logic [IndexBits-1:0] hidx, bidx, gidx;
    logic                 v_hist, v_gsh, v_bias;
    logic [3:0]           vote;
    int                   n, top, cap;
    out_word_t            r;
    hidx   = branch_history;
    bidx   = w.branch_address[IndexBits-1:0];
    gidx   = hidx ^ bidx;
    v_hist = history_ctr[hidx] > 0;
    v_gsh  = gshare_ctr[gidx] > 0;
    v_bias = last_taken[bidx];
    vote   = {v_gsh | v_bias, v_hist, v_gsh, v_bias};
    r.prediction = VoteTakenMask[vote];
    r.correct    = r.prediction == w.outcome_taken;
    // size zero behaves as one; bound clamped to what the counter can hold
    n   = (counter_size == '0) ? 1 : int'(counter_size);
    top = 1 << (n - 1);
    cap = (1 << (CounterWidth - 1)) - 1;
    if (top > cap) top = cap;
    gshare_ctr[gidx]  = step_counter(gshare_ctr[gidx], w.outcome_taken, 1 - top, top);
    history_ctr[hidx] = step_counter(history_ctr[hidx], w.outcome_taken, 1 - top, top);
    last_taken[bidx]  = w.outcome_taken;
    if (r.correct && hit_total != '1) hit_total++;
    if (branch_total != '1) branch_total++;
    branch_history = {branch_history[IndexBits-2:0], w.outcome_taken};
    r.hit_count    = hit_total;
    r.branch_count = branch_total;
    return r;
  endfunction

  function automatic in_word_t random_branch();
    in_word_t w;
    int       k;
    if ($urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, 7);
      loop_trip[k]++;
      w.branch_address = loop_addr[k];
      w.outcome_taken  = (loop_trip[k] % loop_period[k]) != 0;
      if ($urandom_range(0, 15) == 0) w.outcome_taken = ~w.outcome_taken;
    end else begin
      w.branch_address = AddressWidth'({$urandom, $urandom});
      w.outcome_taken  = 1'($urandom_range(0, 1));
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < 50) begin
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
    end
    mismatches++;
  endtask

  // result checking
  out_word_t oldest;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_word_o.branch_count, 0);
      end else begin
        oldest = expected_words.pop_front();
        if (out_word_o.prediction !== oldest.prediction)
          report_mismatch("prediction", out_word_o.prediction, oldest.prediction);
        if (out_word_o.correct !== oldest.correct)
          report_mismatch("correct", out_word_o.correct, oldest.correct);
        if (out_word_o.hit_count !== oldest.hit_count)
          report_mismatch("hit_count", out_word_o.hit_count, oldest.hit_count);
        if (out_word_o.branch_count !== oldest.branch_count)
          report_mismatch("branch_count", out_word_o.branch_count, oldest.branch_count);
      end
    end
  end

  // receiver: random stall bursts, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_len) @(negedge clk_i);
        rx_hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    expected_words.push_back(predict_branch(w));
    words_sent++;
  endtask

  task automatic send_branch(input logic [AddressWidth-1:0] addr, input logic taken);
    in_word_t w;
    w.branch_address = addr;
    w.outcome_taken  = taken;
    send_word(w);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_counter_bits(input logic [CfgWidth-1:0] value);
    stop_input();
    wait_drain();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    counter_size = value;
    sizes_used[value] = 1'b1;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    send_branch('0, 1'b1);
    send_branch('0, 1'b1);
    send_branch('0, 1'b0);
    send_branch('1, 1'b1);
    send_branch('1, 1'b0);
    send_branch(48'hAAAA_AAAA_AAAA, 1'b1);
    send_branch(48'h5555_5555_5555, 1'b0);
    send_branch(48'h0000_0000_0FFF, 1'b1);
    send_branch(48'hFFFF_FFFF_F000, 1'b1);
    // same branch: bias bit and both counters walk both ways
    repeat (6) send_branch(48'h8000_0000_0123, 1'b1);
    repeat (3) send_branch(48'h8000_0000_0123, 1'b0);
    send_branch(48'h7FFF_FFFF_FEDC, 1'b1);
    stop_input();
  endtask

  task automatic test_counter_size_zero();
    write_counter_bits(3'd0);
    repeat (20) send_word(random_branch());
    stop_input();
  endtask

  // widest counters: drive one branch to the top bound, then far down
  task automatic test_saturation_widest();
    write_counter_bits(3'd7);
    repeat (90) send_branch(48'h0000_0000_C0DE, 1'b1);
    repeat (140) send_branch(48'h0000_0000_C0DE, 1'b0);
    stop_input();
  endtask

  // narrowest counters after wide ones: values outside the bounds stay put
  task automatic test_narrow_after_wide();
    write_counter_bits(3'd1);
    repeat (10) send_branch(48'h0000_0000_C0DE, 1'b0);
    repeat (20) send_word(random_branch());
    stop_input();
  endtask

  task automatic test_output_hold_off();
    write_counter_bits(3'd2);
    rx_hold_len = 300;
    repeat (40) send_word(random_branch());
    stop_input();
  endtask

  task automatic test_drain_pause();
    repeat (15) send_word(random_branch());
    stop_input();
    wait_drain();
    repeat (15) send_word(random_branch());
    stop_input();
  endtask

  task automatic test_random_mix();
    logic [CfgWidth-1:0] sizes [4];
    sizes = '{3'd3, 3'd5, 3'd6, CfgWidth'($urandom_range(0, 7))};
    foreach (sizes[p]) begin
      write_counter_bits(sizes[p]);
      repeat (25) send_word(random_branch());
    end
    stop_input();
  endtask

  task automatic test_streaming();
    write_counter_bits(3'd4);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (60) send_word(random_branch());
    stop_input();
  endtask

  initial begin
    branch_history = '0;
    hit_total      = '0;
    branch_total   = '0;
    counter_size   = CounterBitsReset;
    sizes_used[CounterBitsReset] = 1'b1;
    for (int i = 0; i < TableDepth; i++) begin
      history_ctr[i] = ctr_t'(-1);
      gshare_ctr[i]  = ctr_t'(-1);
      last_taken[i]  = 1'b0;
    end
    for (int k = 0; k < 8; k++) begin
      loop_addr[k]   = AddressWidth'({$urandom, $urandom});
      loop_period[k] = $urandom_range(2, 9);
      loop_trip[k]   = 0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_counter_size_zero();
    test_saturation_widest();
    test_narrow_after_wide();
    test_output_hold_off();
    test_drain_pause();
    test_random_mix();
    test_streaming();

    wait_drain();
    repeat (10) @(posedge clk_i);
    $display("checked %0d results for %0d branches, counter sizes used %b",
             results_seen, words_sent, sizes_used);
    $display("covered saturation at both widths, output hold-off, drain pause and streaming");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("hybrid_vote_branch_predictor_test: PASS");
    end else begin
      $display("hybrid_vote_branch_predictor_test: FAIL");
    end
    $finish;
  end

endmodule
